FILE: hdl/nnhd_pkg.sv
// Shared constants, command and status types for the nearest neighbor half distance block.
package nnhd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IN_COORD_W = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int TIDX_W     = 6;
  localparam int RADIUS_W   = 24;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};
  localparam int FRAC_SHIFT = 14;
  localparam int SQR_W      = 2 * COORD_BITS;
  localparam int DSQ_W      = SQR_W + 1;
  localparam int SQV_RAW    = DSQ_W + FRAC_SHIFT;
  localparam int SQV_W      = SQV_RAW + (SQV_RAW % 2);
  localparam int ROOT_W     = SQV_W / 2;
  localparam int SAT_W      = (ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W;
  localparam int SQC_W      = $clog2(ROOT_W + 1);
  localparam int ENTRY_W    = 2 * COORD_BITS + 1;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             pick_i;
    logic             cmp_issue;
    logic             sqrt_start;
  } nnhd_cmd_t;

  typedef struct packed {
    logic kind;
    logic sqrt_busy;
  } nnhd_stat_t;

endpackage

FILE: hdl/nnhd_isqrt.sv
// Iterative integer square root, one root bit per cycle.
module nnhd_isqrt
  import nnhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQV_W-1:0]  value,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [SQV_W-1:0]  val;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic [SQC_W-1:0]  cnt;

  assign rem_sh = {rem[ROOT_W-1:0], val[SQV_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= SQC_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - SQC_W'(1);
      if (cnt == SQC_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[SQV_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/nnhd_datapath.sv
// Point memory, squared distance pipeline, running minimum and radius unit.
module nnhd_datapath
  import nnhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  nnhd_cmd_t             cmd,
  output nnhd_stat_t            stat,
  input  logic [IN_COORD_W-1:0] in_x,
  input  logic [IN_COORD_W-1:0] in_y,
  input  logic                  in_depot,
  output logic [RADIUS_W-1:0]   radius,
  output logic                  no_neighbor
);

  logic [ENTRY_W-1:0]    mem [MAX_POINTS];
  logic [ENTRY_W-1:0]    rdata;
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;
  logic [COORD_BITS-1:0] pi_x;
  logic [COORD_BITS-1:0] pi_y;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [SQR_W-1:0]      sqx;
  logic [SQR_W-1:0]      sqy;
  logic [DSQ_W-1:0]      sum;
  logic [DSQ_W-1:0]      best;
  logic                  found;
  logic                  v1;
  logic                  v2;
  logic                  sqrt_busy;
  logic [ROOT_W-1:0]     root;
  logic [SAT_W-1:0]      root_ext;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= {in_depot, COORD_BITS'(in_y), COORD_BITS'(in_x)};
    end
    rdata <= mem[cmd.rd_addr];
  end

  assign rd_x = rdata[COORD_BITS-1:0];
  assign rd_y = rdata[2*COORD_BITS-1:COORD_BITS];
  assign dx   = (pi_x > rd_x) ? pi_x - rd_x : rd_x - pi_x;
  assign dy   = (pi_y > rd_y) ? pi_y - rd_y : rd_y - pi_y;
  assign sum  = DSQ_W'(sqx) + DSQ_W'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      found <= 1'b0;
    end else begin
      v1 <= cmd.cmp_issue;
      v2 <= v1;
      if (cmd.pick_i) begin
        found <= 1'b0;
      end else if (v2) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_i) begin
      pi_x <= rd_x;
      pi_y <= rd_y;
    end
    sqx <= SQR_W'(dx) * SQR_W'(dx);
    sqy <= SQR_W'(dy) * SQR_W'(dy);
    if (v2 && (!found || sum < best)) begin
      best <= sum;
    end
  end

  nnhd_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .value (SQV_W'({best, FRAC_SHIFT'(0)})),
    .busy  (sqrt_busy),
    .root  (root)
  );

  assign root_ext    = SAT_W'(root);
  assign no_neighbor = !found;
  assign radius      = (!found || root_ext > SAT_W'(RADIUS_MAX)) ? RADIUS_MAX
                                                                   : RADIUS_W'(root_ext);

  assign stat.kind      = rdata[ENTRY_W-1];
  assign stat.sqrt_busy = sqrt_busy;

  a_sqrt_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |=> stat.sqrt_busy)
    else $error("square root unit did not start");

endmodule

FILE: hdl/nnhd_ctrl.sv
// Controller: point loading, target and neighbor sequencing, result handshake.
module nnhd_ctrl
  import nnhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_depot,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TIDX_W-1:0] out_index,
  output logic              out_last,
  output nnhd_cmd_t         cmd,
  input  nnhd_stat_t        stat
);

  typedef enum logic [3:0] {
    S_LOAD, S_RD_I, S_CHK_I, S_SCAN, S_DR1, S_DR2, S_SQ_START, S_SQ_RUN, S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] targets;
  logic [CNT_W-1:0] i_idx;
  logic [CNT_W-1:0] j_idx;
  logic [IDX_W-1:0] emitted;
  logic             full;
  logic             i_last;

  assign full      = (count == CNT_W'(MAX_POINTS));
  assign i_last    = ((i_idx + CNT_W'(1)) == count);
  assign in_ready  = (state == S_LOAD);
  assign out_index = TIDX_W'(emitted);
  assign out_last  = ((CNT_W'(emitted) + CNT_W'(1)) == targets);

  always_comb begin
    cmd.wr_en      = (state == S_LOAD) && in_valid && !full;
    cmd.wr_addr    = count[IDX_W-1:0];
    cmd.rd_addr    = (state == S_SCAN) ? j_idx[IDX_W-1:0] : i_idx[IDX_W-1:0];
    cmd.pick_i     = (state == S_CHK_I) && !stat.kind;
    cmd.cmp_issue  = (state == S_SCAN) && (j_idx != i_idx);
    cmd.sqrt_start = (state == S_SQ_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      targets   <= '0;
      i_idx     <= '0;
      j_idx     <= '0;
      emitted   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (!full) begin
              count <= count + CNT_W'(1);
              if (!in_depot) begin
                targets <= targets + CNT_W'(1);
              end
            end
            if (in_last) begin
              i_idx   <= '0;
              emitted <= '0;
              state   <= S_RD_I;
            end
          end
        end
        S_RD_I: state <= S_CHK_I;
        S_CHK_I: begin
          if (stat.kind) begin
            if (i_last) begin
              count   <= '0;
              targets <= '0;
              state   <= S_LOAD;
            end else begin
              i_idx <= i_idx + CNT_W'(1);
              state <= S_RD_I;
            end
          end else begin
            j_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          j_idx <= j_idx + CNT_W'(1);
          if ((j_idx + CNT_W'(1)) == count) begin
            state <= S_DR1;
          end
        end
        S_DR1:      state <= S_DR2;
        S_DR2:      state <= S_SQ_START;
        S_SQ_START: state <= S_SQ_RUN;
        S_SQ_RUN: begin
          if (!stat.sqrt_busy) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            emitted   <= emitted + IDX_W'(1);
            if (i_last) begin
              count   <= '0;
              targets <= '0;
              state   <= S_LOAD;
            end else begin
              i_idx <= i_idx + CNT_W'(1);
              state <= S_RD_I;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (j_idx < count))
    else $error("neighbor index beyond stored points");

  a_result_has_target: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (targets != '0))
    else $error("result presented with no stored target");

endmodule

FILE: hdl/nearest_neighbor_half_distance_top.sv
// Top level of the nearest neighbor half distance block.
//
// Points stream in one word per cycle while s_axis_tready is high and are
// stored (up to MAX_POINTS; later ones are dropped). The word marked tlast
// starts the search: for each stored target in arrival order the block scans
// every stored point through a single read port of the point memory, one
// point per cycle, then takes the square root one bit per cycle. No new point
// is taken until the last result of the set has been delivered. Result tdata
// carries the target index and half the nearest distance with 8 fraction
// bits; tuser flags a target with no other point, and tlast marks the final
// target.
module nearest_neighbor_half_distance_top
  import nnhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // point_x[15:0], point_y[31:16]
  input  logic        s_axis_tuser,   // is_depot
  input  logic        s_axis_tlast,   // last_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // target_index[5:0], radius_fx[29:6], zero[31:30]
  output logic        m_axis_tuser,   // no_neighbor
  output logic        m_axis_tlast    // last_result
);

  nnhd_cmd_t           cmd;
  nnhd_stat_t          stat;
  logic [TIDX_W-1:0]   out_index;
  logic [RADIUS_W-1:0] radius;
  logic                no_neighbor;

  nnhd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_depot  (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (out_index),
    .out_last  (m_axis_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

  nnhd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_x        (s_axis_tdata[15:0]),
    .in_y        (s_axis_tdata[31:16]),
    .in_depot    (s_axis_tuser),
    .radius      (radius),
    .no_neighbor (no_neighbor)
  );

  assign m_axis_tdata = {2'b00, radius, out_index};
  assign m_axis_tuser = no_neighbor;

endmodule
